/* rtl/one_shot_timer_table_macros.svh */
// assertion macros for the one-shot timer table
// used by one_shot_timer_table.sv, no other dependencies
`ifndef ONE_SHOT_TIMER_TABLE_MACROS_SVH
`define ONE_SHOT_TIMER_TABLE_MACROS_SVH

// condition holds in the same cycle
`define OSTT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ostt same-cycle check failed");

// condition holds in the next cycle
`define OSTT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ostt next-cycle check failed");

`endif

/* rtl/ostt_pkg.sv */
// package for the one-shot timer table: sizes, codes and sequencer states
// no dependencies
`default_nettype none

package ostt_pkg;

   localparam int SLOTS         = 16;
   localparam int SLOT_BITS     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int ID_BITS       = 8;
   localparam int DURATION_BITS = 16;
   localparam int OP_BITS       = 3;
   localparam int KIND_BITS     = 2;
   localparam int STATUS_BITS   = 2;

   typedef enum logic [OP_BITS-1:0] {
      OP_CREATE   = 3'd0,
      OP_DELETE   = 3'd1,
      OP_SET_DUR  = 3'd2,
      OP_START    = 3'd3,
      OP_STOP     = 3'd4,
      OP_TICK     = 3'd5
   } op_type;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_STATUS = 2'd0,
      KIND_FIRED  = 2'd1,
      KIND_DONE   = 2'd2
   } kind_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_DUP       = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SEQ_IDLE   = 2'd0,
      SEQ_SCAN   = 2'd1,
      SEQ_FINISH = 2'd2
   } seq_state_type;

endpackage

`default_nettype wire

/* rtl/ostt_if.sv */
// handshake channels of the one-shot timer table: request and response
// depends on ostt_pkg
`default_nettype none

interface ostt_req_if;
   logic                               valid;
   logic                               ready;
   logic [ostt_pkg::OP_BITS-1:0]       op;
   logic [ostt_pkg::ID_BITS-1:0]       timer_id;
   logic [ostt_pkg::DURATION_BITS-1:0] duration;

   modport source (output valid, op, timer_id, duration, input ready);
   modport sink   (input valid, op, timer_id, duration, output ready);
endinterface

interface ostt_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [ostt_pkg::KIND_BITS-1:0]   kind;
   logic [ostt_pkg::STATUS_BITS-1:0] status;
   logic [ostt_pkg::ID_BITS-1:0]     fired_id;
   logic                             last;

   modport source (output valid, kind, status, fired_id, last, input ready);
   modport sink   (input valid, kind, status, fired_id, last, output ready);
endinterface

`default_nettype wire

/* rtl/one_shot_timer_table.sv */
// one-shot timer table: slot store, scan sequencer and response register
// depends on ostt_pkg, ostt_if.sv and one_shot_timer_table_macros.svh
// a command item scans every slot, then the finish state registers its status item
// a tick item scans one slot per cycle while the response register is free, then its done item
// one item at a time: next accept the cycle after the final item is registered
// synchronous reset clears the slot valid and running bits, the sequencer and rsp valid
`default_nettype none

`include "one_shot_timer_table_macros.svh"

module one_shot_timer_table (
   input  wire logic  clock,
   input  wire logic  reset,
   ostt_req_if.sink   req_chan,
   ostt_rsp_if.source rsp_chan
);

   localparam int SB = ostt_pkg::SLOT_BITS;
   localparam int IB = ostt_pkg::ID_BITS;
   localparam int DB = ostt_pkg::DURATION_BITS;
   localparam logic [SB-1:0] LAST_SLOT = SB'(ostt_pkg::SLOTS - 1);

   // slot store
   logic          valid_ff  [ostt_pkg::SLOTS];
   logic          active_ff [ostt_pkg::SLOTS];
   logic [IB-1:0] id_ff     [ostt_pkg::SLOTS];
   logic [DB-1:0] dur_ff    [ostt_pkg::SLOTS];
   logic [DB-1:0] rem_ff    [ostt_pkg::SLOTS];

   // sequencer and captured item
   ostt_pkg::seq_state_type state_ff, state_in;
   logic [SB-1:0]    idx_ff, idx_in;
   ostt_pkg::op_type op_ff, op_in;
   logic [IB-1:0]    req_id_ff, req_id_in;
   logic [DB-1:0]    req_dur_ff, req_dur_in;
   logic             hit_ff, hit_in;
   logic [SB-1:0]    hit_slot_ff, hit_slot_in;
   logic             hit_active_ff, hit_active_in;
   logic [DB-1:0]    hit_dur_ff, hit_dur_in;
   logic [DB-1:0]    hit_rem_ff, hit_rem_in;
   logic             free_ff, free_in;
   logic [SB-1:0]    free_slot_ff, free_slot_in;

   // response register
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [ostt_pkg::KIND_BITS-1:0]   rsp_kind_ff, rsp_kind_in;
   logic [ostt_pkg::STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;
   logic [IB-1:0]                    rsp_fired_ff, rsp_fired_in;
   logic                             rsp_last_ff, rsp_last_in;

   // single slot write port
   logic          wr_en;
   logic [SB-1:0] wr_slot;
   logic          wr_valid, wr_active;
   logic [IB-1:0] wr_id;
   logic [DB-1:0] wr_dur, wr_rem;

   logic          req_accept, out_free, scan_go, is_tick;
   logic          rd_valid, rd_active;
   logic [IB-1:0] rd_id;
   logic [DB-1:0] rd_dur, rd_rem, rem_dec;

   assign req_chan.ready  = (state_ff == ostt_pkg::SEQ_IDLE);
   assign req_accept      = req_chan.valid && req_chan.ready;
   assign out_free        = !rsp_valid_ff || rsp_chan.ready;
   assign is_tick         = (op_ff == ostt_pkg::OP_TICK);
   assign scan_go         = !is_tick || out_free;

   assign rd_valid  = valid_ff[idx_ff];
   assign rd_active = active_ff[idx_ff];
   assign rd_id     = id_ff[idx_ff];
   assign rd_dur    = dur_ff[idx_ff];
   assign rd_rem    = rem_ff[idx_ff];

   // shared countdown unit, saturating at zero
   assign rem_dec = (rd_rem != '0) ? (rd_rem - DB'(1)) : '0;

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.kind     = rsp_kind_ff;
   assign rsp_chan.status   = rsp_status_ff;
   assign rsp_chan.fired_id = rsp_fired_ff;
   assign rsp_chan.last     = rsp_last_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ostt_pkg::SEQ_IDLE: begin
            if (req_accept) state_in = ostt_pkg::SEQ_SCAN;
         end
         ostt_pkg::SEQ_SCAN: begin
            if (scan_go && (idx_ff == LAST_SLOT)) state_in = ostt_pkg::SEQ_FINISH;
         end
         ostt_pkg::SEQ_FINISH: begin
            if (out_free) state_in = ostt_pkg::SEQ_IDLE;
         end
         default: state_in = ostt_pkg::SEQ_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      idx_in        = idx_ff;
      op_in         = op_ff;
      req_id_in     = req_id_ff;
      req_dur_in    = req_dur_ff;
      hit_in        = hit_ff;
      hit_slot_in   = hit_slot_ff;
      hit_active_in = hit_active_ff;
      hit_dur_in    = hit_dur_ff;
      hit_rem_in    = hit_rem_ff;
      free_in       = free_ff;
      free_slot_in  = free_slot_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_status_in = rsp_status_ff;
      rsp_fired_in  = rsp_fired_ff;
      rsp_last_in   = rsp_last_ff;

      wr_en     = 1'b0;
      wr_slot   = idx_ff;
      wr_valid  = rd_valid;
      wr_active = rd_active;
      wr_id     = rd_id;
      wr_dur    = rd_dur;
      wr_rem    = rd_rem;

      unique case (state_ff)
         ostt_pkg::SEQ_IDLE: begin
            if (req_accept) begin
               op_in      = ostt_pkg::op_type'(req_chan.op);
               req_id_in  = req_chan.timer_id;
               req_dur_in = req_chan.duration;
               idx_in     = '0;
               hit_in     = 1'b0;
               free_in    = 1'b0;
            end
         end
         ostt_pkg::SEQ_SCAN: begin
            if (scan_go) begin
               idx_in = idx_ff + SB'(1);
               if (is_tick) begin
                  if (rd_valid && rd_active) begin
                     wr_en     = 1'b1;
                     wr_rem    = rem_dec;
                     wr_active = (rem_dec != '0);
                     if (rem_dec == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_kind_in   = ostt_pkg::KIND_FIRED;
                        rsp_status_in = ostt_pkg::ST_OK;
                        rsp_fired_in  = rd_id;
                        rsp_last_in   = 1'b0;
                     end
                  end
               end else begin
                  if (rd_valid && (rd_id == req_id_ff) && !hit_ff) begin
                     hit_in        = 1'b1;
                     hit_slot_in   = idx_ff;
                     hit_active_in = rd_active;
                     hit_dur_in    = rd_dur;
                     hit_rem_in    = rd_rem;
                  end
                  if (!rd_valid && !free_ff) begin
                     free_in      = 1'b1;
                     free_slot_in = idx_ff;
                  end
               end
            end
         end
         ostt_pkg::SEQ_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = ostt_pkg::KIND_STATUS;
               rsp_status_in = ostt_pkg::ST_OK;
               rsp_fired_in  = '0;
               rsp_last_in   = 1'b1;
               wr_slot       = hit_slot_ff;
               wr_valid      = 1'b1;
               wr_active     = hit_active_ff;
               wr_id         = req_id_ff;
               wr_dur        = hit_dur_ff;
               wr_rem        = hit_rem_ff;
               unique case (op_ff)
                  ostt_pkg::OP_TICK: begin
                     rsp_kind_in = ostt_pkg::KIND_DONE;
                  end
                  ostt_pkg::OP_CREATE: begin
                     if (hit_ff) begin
                        rsp_status_in = ostt_pkg::ST_DUP;
                     end else if (!free_ff) begin
                        rsp_status_in = ostt_pkg::ST_FULL;
                     end else begin
                        wr_en     = 1'b1;
                        wr_slot   = free_slot_ff;
                        wr_active = 1'b0;
                        wr_dur    = req_dur_ff;
                        wr_rem    = '0;
                     end
                  end
                  ostt_pkg::OP_DELETE: begin
                     wr_en     = hit_ff;
                     wr_valid  = 1'b0;
                     wr_active = 1'b0;
                     wr_rem    = '0;
                  end
                  ostt_pkg::OP_SET_DUR: begin
                     wr_en  = hit_ff;
                     wr_dur = req_dur_ff;
                     if (hit_active_ff) wr_rem = req_dur_ff;
                  end
                  ostt_pkg::OP_START: begin
                     wr_en     = hit_ff;
                     wr_active = 1'b1;
                     wr_rem    = hit_dur_ff;
                  end
                  ostt_pkg::OP_STOP: begin
                     wr_en     = hit_ff;
                     wr_active = 1'b0;
                  end
                  default: ;
               endcase
               if (!hit_ff && (op_ff == ostt_pkg::OP_DELETE || op_ff == ostt_pkg::OP_SET_DUR ||
                               op_ff == ostt_pkg::OP_START || op_ff == ostt_pkg::OP_STOP)) begin
                  rsp_status_in = ostt_pkg::ST_NOT_FOUND;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ostt_pkg::SEQ_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ostt_pkg::SLOTS; i++) begin
            valid_ff[i]  <= 1'b0;
            active_ff[i] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            valid_ff[wr_slot]  <= wr_valid;
            active_ff[wr_slot] <= wr_active;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      op_ff         <= op_in;
      req_id_ff     <= req_id_in;
      req_dur_ff    <= req_dur_in;
      hit_ff        <= hit_in;
      hit_slot_ff   <= hit_slot_in;
      hit_active_ff <= hit_active_in;
      hit_dur_ff    <= hit_dur_in;
      hit_rem_ff    <= hit_rem_in;
      free_ff       <= free_in;
      free_slot_ff  <= free_slot_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fired_ff  <= rsp_fired_in;
      rsp_last_ff   <= rsp_last_in;
      if (wr_en) begin
         id_ff[wr_slot]  <= wr_id;
         dur_ff[wr_slot] <= wr_dur;
         rem_ff[wr_slot] <= wr_rem;
      end
   end

   `OSTT_ASSERT_NEXT(a_accept_starts_scan, clock, reset, req_accept,
      state_ff == ostt_pkg::SEQ_SCAN && idx_ff == '0)
   `OSTT_ASSERT_NOW(a_finish_after_last_slot, clock, reset,
      state_ff == ostt_pkg::SEQ_FINISH, idx_ff == '0)
   `OSTT_ASSERT_NEXT(a_finish_gives_last, clock, reset,
      state_ff == ostt_pkg::SEQ_FINISH && out_free, rsp_valid_ff && rsp_last_ff)

endmodule

`default_nettype wire
